// File: rtl/rsched_pkg.sv
package rsched_pkg;

   localparam int SLOT_COUNT = 32;
   localparam int TIME_BITS  = 16;
   localparam int SOUND_W    = 11;
   localparam int POS_W      = 16;
   localparam int COUNT_W    = 7;
   localparam int PLAYS_W    = 8;
   localparam int MODE_W     = 2;
   localparam int OP_W       = 2;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   localparam logic [IDX_W-1:0] LAST_SLOT    = IDX_W'(SLOT_COUNT - 1);
   localparam logic [CNT_W-1:0] SLOT_CNT_END = CNT_W'(SLOT_COUNT);

   localparam logic [TIME_BITS-1:0] FRAME_STEP_RESET = TIME_BITS'(4);

   // Operation codes
   localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

   // Slot modes
   localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELAY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_GAP   = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]      operation;
      logic [SOUND_W-1:0]   sound_id;
      logic [TIME_BITS-1:0] start_delay;
      logic [COUNT_W-1:0]   play_total;
      logic [TIME_BITS-1:0] repeat_gap;
      logic [POS_W-1:0]     position_tag;
   } req_type;

   typedef struct packed {
      logic [SOUND_W-1:0] play_sound;
      logic [POS_W-1:0]   play_position;
      logic               immediate;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [SOUND_W-1:0]   sound;
      logic [PLAYS_W-1:0]   plays_left;
      logic [TIME_BITS-1:0] timer;
      logic [TIME_BITS-1:0] gap;
      logic [POS_W-1:0]     position;
   } slot_type;

   typedef struct packed {
      logic [SOUND_W-1:0] sound;
      logic [POS_W-1:0]   position;
   } event_type;

   // Commands into the output stage
   typedef struct packed {
      logic imm_load;   // immediate play from a schedule request
      logic slot_play;  // a slot plays during the sweep
      logic flush;      // end of sweep, release the held event as last
   } emit_ctl_type;

   typedef struct packed {
      logic out_free;   // output register can take an item this cycle
      logic pend_v;     // an event is held waiting to learn if it is last
   } emit_sts_type;

endpackage

// File: rtl/rsched_ram.sv
module rsched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rsched_emit.sv
module rsched_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  rsched_pkg::emit_ctl_type ctl,
   input  rsched_pkg::event_type    ev,
   output rsched_pkg::emit_sts_type sts,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsched_pkg::rsp_type      rsp_data
);

   logic                  out_v_ff, out_v_in;
   rsched_pkg::rsp_type   out_ff, out_in;
   logic                  pend_v_ff, pend_v_in;
   rsched_pkg::event_type pend_ff, pend_in;
   logic                  out_free;

   assign out_free = !out_v_ff || !rsp_stall;

   always_comb begin
      out_v_in  = out_v_ff && rsp_stall;
      out_in    = out_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      if (ctl.imm_load) begin
         out_v_in = 1'b1;
         out_in   = '{play_sound: ev.sound, play_position: ev.position,
                      immediate: 1'b1, last: 1'b1};
      end
      if (ctl.slot_play) begin
         // push the held event out, it is not the last one
         if (pend_v_ff) begin
            out_v_in = 1'b1;
            out_in   = '{play_sound: pend_ff.sound, play_position: pend_ff.position,
                         immediate: 1'b0, last: 1'b0};
         end
         pend_v_in = 1'b1;
         pend_in   = ev;
      end
      if (ctl.flush) begin
         out_v_in  = 1'b1;
         out_in    = '{play_sound: pend_ff.sound, play_position: pend_ff.position,
                       immediate: 1'b0, last: 1'b1};
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         pend_v_ff <= pend_v_in;
      end
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign sts.out_free = out_free;
   assign sts.pend_v   = pend_v_ff;
   assign rsp_valid    = out_v_ff;
   assign rsp_data     = out_ff;

endmodule

// File: rtl/repeat_event_scheduler.sv
// Repeat event scheduler: 32 sound slots in one synchronous RAM, each with a
// sound id, position tag, plays left, countdown timer and repeat gap (unsigned
// Q8.8 seconds). A schedule item with one play and no delay goes straight to
// the output as an immediate play; any other schedule overwrites the slot at a
// wrapping write pointer. Schedule, clear and the unused code are handled in idle, with no sweep.
// A tick sweeps the RAM one slot per cycle, unless the output stage stalls it,
// through a read-modify-write stage: it reads every slot, finishes the last
// slot, sees the stage empty and then releases the held event, and only then
// is the next item taken, later still if the result side stalls; play events
// come out in slot order and the last one of the tick carries last. Each play
// event is held back until the next one or the end of the sweep, so that last
// can be set on the final one. Per-slot valid flops stand for the reset value,
// so reset and clear take effect at once with no clearing pass. New items are
// stalled while a tick is in progress or while a finished item waits in the
// output register. Write frame_step only while the block is idle.
module repeat_event_scheduler (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rsched_pkg::req_type                    req_data,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rsched_pkg::rsp_type                    rsp_data,
   // frame_step register
   input  logic                                   csr_we,
   input  logic [rsched_pkg::TIME_BITS-1:0]        csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff, state_in;

   logic [rsched_pkg::TIME_BITS-1:0]  step_ff;
   logic [rsched_pkg::IDX_W-1:0]      wp_ff, wp_in;
   logic [rsched_pkg::SLOT_COUNT-1:0] slot_valid_ff, slot_valid_in;
   logic [rsched_pkg::CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;

   // read stage: the RAM registers the slot data, which arrives the cycle after the read
   logic                          s1_v_ff, s1_v_in;
   logic [rsched_pkg::IDX_W-1:0]  s1_idx_ff, s1_idx_in;
   logic                          s1_hit_ff, s1_hit_in;

   logic req_fire, is_imm, sched_store, tick_start, clear_all;
   logic issued_all, proc_stall, advance;

   logic                          rd_en;
   logic [rsched_pkg::IDX_W-1:0]  rd_addr;
   rsched_pkg::slot_type          rd_slot;
   logic                          wr_en;
   logic [rsched_pkg::IDX_W-1:0]  wr_addr;
   rsched_pkg::slot_type          wr_slot;

   rsched_pkg::slot_type          cur, nxt, new_slot;
   logic                          proc, proc_wr, proc_free, proc_play;

   rsched_pkg::emit_ctl_type      emit_ctl;
   rsched_pkg::emit_sts_type      emit_sts;
   rsched_pkg::event_type         emit_ev;

   // ---------------------------------------------------------------- requests
   assign req_stall   = (state_ff != ST_IDLE) || !emit_sts.out_free;
   assign req_fire    = req_valid && !req_stall;
   assign is_imm      = (req_data.play_total == rsched_pkg::COUNT_W'(1))
                        && (req_data.start_delay == '0);
   assign sched_store = req_fire && (req_data.operation == rsched_pkg::OP_SCHEDULE) && !is_imm;
   assign tick_start  = req_fire && (req_data.operation == rsched_pkg::OP_TICK);
   assign clear_all   = req_fire && (req_data.operation == rsched_pkg::OP_CLEAR);

   // build the slot a stored schedule writes; zero plays count as one
   always_comb begin
      new_slot.mode       = (req_data.start_delay != '0) ? rsched_pkg::MODE_DELAY
                                                         : rsched_pkg::MODE_PLAY;
      new_slot.sound      = req_data.sound_id;
      new_slot.timer      = req_data.start_delay;
      new_slot.plays_left = (req_data.play_total == '0) ? rsched_pkg::PLAYS_W'(1)
                                                        : {1'b0, req_data.play_total};
      new_slot.gap        = req_data.repeat_gap;
      new_slot.position   = req_data.position_tag;
   end

   // ------------------------------------------------------------------ sweep
   assign issued_all = (rd_cnt_ff == rsched_pkg::SLOT_CNT_END);
   assign rd_addr    = rd_cnt_ff[rsched_pkg::IDX_W-1:0];

   // a never-written or freed slot reads as all zero (inactive)
   assign cur = s1_hit_ff ? rd_slot : '0;

   // hold the stage when a second play needs the output register and it is full
   assign proc_stall = s1_v_ff && (cur.mode == rsched_pkg::MODE_PLAY)
                       && emit_sts.pend_v && !emit_sts.out_free;
   assign advance    = !proc_stall;
   assign rd_en      = (state_ff == ST_SWEEP) && !issued_all && advance;
   assign proc       = s1_v_ff && advance;

   always_comb begin
      nxt       = cur;
      proc_wr   = 1'b0;
      proc_free = 1'b0;
      proc_play = 1'b0;
      case (cur.mode)
         rsched_pkg::MODE_DELAY, rsched_pkg::MODE_GAP: begin
            proc_wr = 1'b1;
            if (cur.timer != '0) begin
               // count down, saturate at zero
               nxt.timer = (cur.timer > step_ff) ? cur.timer - step_ff : '0;
            end else begin
               nxt.mode = rsched_pkg::MODE_PLAY;
            end
         end
         rsched_pkg::MODE_PLAY: begin
            proc_play = 1'b1;
            if (cur.plays_left > rsched_pkg::PLAYS_W'(1)) begin
               proc_wr        = 1'b1;
               nxt.plays_left = cur.plays_left - rsched_pkg::PLAYS_W'(1);
               nxt.timer      = cur.gap;
               nxt.mode       = rsched_pkg::MODE_GAP;
            end else begin
               proc_free = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- RAM port
   always_comb begin
      if (sched_store) begin
         wr_en   = 1'b1;
         wr_addr = wp_ff;
         wr_slot = new_slot;
      end else begin
         wr_en   = proc && proc_wr;
         wr_addr = s1_idx_ff;
         wr_slot = nxt;
      end
   end

   rsched_ram #(
      .WIDTH ($bits(rsched_pkg::slot_type)),
      .DEPTH (rsched_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_slot)
   );

   // ------------------------------------------------------------ output stage
   always_comb begin
      emit_ctl.imm_load  = req_fire && (req_data.operation == rsched_pkg::OP_SCHEDULE)
                           && is_imm;
      emit_ctl.slot_play = proc && proc_play;
      emit_ctl.flush     = (state_ff == ST_FLUSH) && emit_sts.pend_v && emit_sts.out_free;
      if (state_ff == ST_IDLE) begin
         emit_ev.sound    = req_data.sound_id;
         emit_ev.position = req_data.position_tag;
      end else begin
         emit_ev.sound    = cur.sound;
         emit_ev.position = cur.position;
      end
   end

   rsched_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (emit_ctl),
      .ev        (emit_ev),
      .sts       (emit_sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ------------------------------------------------------------------ control
   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      slot_valid_in = slot_valid_ff;
      rd_cnt_in     = rd_cnt_ff;
      s1_v_in       = s1_v_ff;
      s1_idx_in     = s1_idx_ff;
      s1_hit_in     = s1_hit_ff;

      if (sched_store) begin
         slot_valid_in[wp_ff] = 1'b1;
         wp_in = (wp_ff == rsched_pkg::LAST_SLOT) ? '0 : wp_ff + rsched_pkg::IDX_W'(1);
      end
      if (clear_all) begin
         slot_valid_in = '0;
         wp_in         = '0;
      end
      // drop a slot whose last play just went out
      if (proc && proc_free) begin
         slot_valid_in[s1_idx_ff] = 1'b0;
      end
      if (rd_en) begin
         rd_cnt_in = rd_cnt_ff + rsched_pkg::CNT_W'(1);
      end
      if (advance) begin
         s1_v_in   = rd_en;
         s1_idx_in = rd_addr;
         s1_hit_in = slot_valid_ff[rd_addr];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (tick_start) begin
               state_in  = ST_SWEEP;
               rd_cnt_in = '0;
            end
         end
         ST_SWEEP: begin
            if (issued_all && !s1_v_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!emit_sts.pend_v || emit_sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= rsched_pkg::FRAME_STEP_RESET;
         wp_ff         <= '0;
         slot_valid_ff <= '0;
         rd_cnt_ff     <= '0;
         s1_v_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         slot_valid_ff <= slot_valid_in;
         rd_cnt_ff     <= rd_cnt_in;
         s1_v_ff       <= s1_v_in;
         if (csr_we) begin
            step_ff <= csr_wdata;
         end
      end
      s1_idx_ff <= s1_idx_in;
      s1_hit_ff <= s1_hit_in;
   end

`ifndef SYNTH
   // the sweep never reads the entry it is writing back
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("slot RAM read and write hit the same entry");

   // no event may be left held once the block is idle
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !emit_sts.pend_v)
      else $error("play event held while idle");

   // read stage only holds a slot during a sweep
   a_s1_in_sweep: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> (state_ff == ST_SWEEP))
      else $error("read stage busy outside a sweep");

   // the sweep counter never runs past the slot count
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (rd_cnt_ff <= rsched_pkg::SLOT_CNT_END))
      else $error("sweep counter out of range");
`endif

endmodule

// File: test/play_event_checker.sv
module play_event_checker
   import rsched_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [TIME_BITS-1:0] csr_wdata,
   output int                   fail_count,
   output int                   pending_plays,
   output int                   tick_count,
   output int                   event_count,
   output int                   immediate_count,
   output int                   widest_tick
);
   timeunit 1ns;
   timeprecision 1ps;

   slot_type             slot_mem [SLOT_COUNT];
   logic [IDX_W-1:0]     write_ptr;
   logic [TIME_BITS-1:0] frame_step;
   rsp_type              play_queue [$];

   task automatic empty_slots();
      foreach (slot_mem[i]) slot_mem[i] = '0;
      write_ptr = '0;
   endtask

   // Advance the slot copy by one request and queue the play events it causes.
   task automatic apply_request(input req_type r);
      rsp_type held;
      bit      have_held;
      int      plays;
      held      = '0;
      have_held = 1'b0;
      plays     = 0;
      case (r.operation)
         OP_SCHEDULE: begin
            if (r.play_total == COUNT_W'(1) && r.start_delay == '0) begin
               held.play_sound    = r.sound_id;
               held.play_position = r.position_tag;
               held.immediate     = 1'b1;
               held.last          = 1'b1;
               play_queue.push_back(held);
            end else begin
               slot_mem[write_ptr].mode       = (r.start_delay != '0) ? MODE_DELAY : MODE_PLAY;
               slot_mem[write_ptr].sound      = r.sound_id;
               slot_mem[write_ptr].timer      = r.start_delay;
               slot_mem[write_ptr].plays_left = (r.play_total == '0) ? PLAYS_W'(1)
                                                                     : PLAYS_W'(r.play_total);
               slot_mem[write_ptr].gap        = r.repeat_gap;
               slot_mem[write_ptr].position   = r.position_tag;
               write_ptr = (write_ptr == LAST_SLOT) ? '0 : write_ptr + 1'b1;
            end
         end
         OP_TICK: begin
            tick_count++;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               case (slot_mem[i].mode)
                  MODE_DELAY, MODE_GAP: begin
                     if (slot_mem[i].timer != '0) begin
                        slot_mem[i].timer = (slot_mem[i].timer > frame_step)
                                          ? slot_mem[i].timer - frame_step : '0;
                     end else begin
                        slot_mem[i].mode = MODE_PLAY;
                     end
                  end
                  MODE_PLAY: begin
                     // hold each event until the next one shows it was not last
                     if (have_held) play_queue.push_back(held);
                     held               = '0;
                     held.play_sound    = slot_mem[i].sound;
                     held.play_position = slot_mem[i].position;
                     have_held          = 1'b1;
                     plays++;
                     if (slot_mem[i].plays_left > 1) begin
                        slot_mem[i].plays_left = slot_mem[i].plays_left - 1'b1;
                        slot_mem[i].timer      = slot_mem[i].gap;
                        slot_mem[i].mode       = MODE_GAP;
                     end else begin
                        slot_mem[i] = '0;
                     end
                  end
                  default: ;
               endcase
            end
            if (have_held) begin
               held.last = 1'b1;
               play_queue.push_back(held);
            end
            if (plays > widest_tick) widest_tick = plays;
         end
         OP_CLEAR: empty_slots();
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         empty_slots();
         frame_step = FRAME_STEP_RESET;
         play_queue.delete();
         fail_count      = 0;
         tick_count      = 0;
         event_count     = 0;
         immediate_count = 0;
         widest_tick     = 0;
      end else begin
         if (csr_we) frame_step = csr_wdata;
         if (req_valid && !req_stall) apply_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (play_queue.size() == 0) begin
               fail_count++;
               $display("%0t unexpected play event: expected none, got %h", $time, rsp_data);
            end else begin
               want = play_queue.pop_front();
               event_count++;
               if (want.immediate) immediate_count++;
               if (rsp_data.play_sound !== want.play_sound) begin
                  fail_count++;
                  $display("%0t play_sound: expected %0d, got %0d",
                           $time, want.play_sound, rsp_data.play_sound);
               end
               if (rsp_data.play_position !== want.play_position) begin
                  fail_count++;
                  $display("%0t play_position: expected %h, got %h",
                           $time, want.play_position, rsp_data.play_position);
               end
               if (rsp_data.immediate !== want.immediate) begin
                  fail_count++;
                  $display("%0t immediate: expected %b, got %b",
                           $time, want.immediate, rsp_data.immediate);
               end
               if (rsp_data.last !== want.last) begin
                  fail_count++;
                  $display("%0t last: expected %b, got %b", $time, want.last, rsp_data.last);
               end
            end
         end
      end
      pending_plays = play_queue.size();
   end

endmodule

// File: test/tb_repeat_event_scheduler.sv
module tb_repeat_event_scheduler;
   timeunit 1ns;
   timeprecision 1ps;
   import rsched_pkg::*;

   // Spare operation code; the block must drop it without a result.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int RESET_CYCLES     = 6;
   localparam int SETTLE_CYCLES    = 48;   // one full sweep plus the held event
   localparam int LONG_HOLD        = 300;  // receiver hold-off that fills the block
   localparam int IDLE_LIMIT       = 2000; // cycles with no item moving on either side
   localparam int PHASES           = 5;
   localparam int RANDOM_PER_PHASE = 66;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [TIME_BITS-1:0] csr_wdata;

   int fail_count;
   int pending_plays;
   int tick_count;
   int event_count;
   int immediate_count;
   int widest_tick;
   int items_sent;

   // Handshake between the stimulus and the receiver for the one long hold-off.
   bit want_long_hold;
   bit long_hold_started;
   bit long_hold_done;

   logic [TIME_BITS-1:0] phase_step [PHASES];

   repeat_event_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   play_event_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_plays   (pending_plays),
      .tick_count      (tick_count),
      .event_count     (event_count),
      .immediate_count (immediate_count),
      .widest_tick     (widest_tick)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Request side helpers. All drives happen on the falling edge.
   // ---------------------------------------------------------------------

   function automatic req_type make_request(input logic [OP_W-1:0]      op,
                                            input logic [SOUND_W-1:0]   snd,
                                            input logic [TIME_BITS-1:0] delay,
                                            input logic [COUNT_W-1:0]   plays,
                                            input logic [TIME_BITS-1:0] gap,
                                            input logic [POS_W-1:0]     pos);
      req_type r;
      r.operation    = op;
      r.sound_id     = snd;
      r.start_delay  = delay;
      r.play_total   = plays;
      r.repeat_gap   = gap;
      r.position_tag = pos;
      return r;
   endfunction

   // Mostly zero or a few frames' worth, sometimes anything, sometimes an extreme.
   function automatic logic [TIME_BITS-1:0] random_time(input int reach);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return '0;
         4, 5, 6:    return TIME_BITS'($urandom_range(1, reach));
         7, 8:       return TIME_BITS'($urandom);
         default:    return ($urandom_range(0, 1) == 0) ? '1 : TIME_BITS'(1);
      endcase
   endfunction

   // Schedules and ticks dominate so slots fill, expire and repeat; clear and
   // the spare code show up now and then. Every field is random on every op.
   function automatic req_type random_request(input logic [TIME_BITS-1:0] step);
      req_type r;
      int      pick;
      int      reach;
      reach = (step == '0) ? 16 : ((int'(step) * 4 > 65535) ? 65535 : int'(step) * 4);
      pick  = $urandom_range(0, 99);
      if (pick < 42)      r.operation = OP_SCHEDULE;
      else if (pick < 92) r.operation = OP_TICK;
      else if (pick < 95) r.operation = OP_CLEAR;
      else                r.operation = OP_UNUSED;
      r.sound_id     = SOUND_W'($urandom);
      r.position_tag = POS_W'($urandom);
      r.start_delay  = random_time(reach);
      r.repeat_gap   = random_time(reach);
      case ($urandom_range(0, 9))
         0, 1, 2: r.play_total = COUNT_W'(1);
         3, 4, 5: r.play_total = COUNT_W'($urandom_range(0, 4));
         6, 7, 8: r.play_total = COUNT_W'($urandom_range(2, 24));
         default: r.play_total = COUNT_W'($urandom);
      endcase
      return r;
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(input req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      items_sent++;
   endtask

   // Drop valid and idle for a number of cycles.
   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stop sending, wait for every predicted play event, then let a sweep
   // that causes no result finish before anything else touches the block.
   task automatic drain_plays();
      pause_sender(0);
      while (pending_plays != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_frame_step(input logic [TIME_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Bursts of random length, mostly short, now and then a long unbroken run.
   task automatic send_random(input int total, input logic [TIME_BITS-1:0] step);
      int sent;
      int burst;
      sent = 0;
      while (sent < total) begin
         burst = ($urandom_range(0, 4) == 0) ? 24 : $urandom_range(1, 8);
         for (int k = 0; k < burst && sent < total; k++) begin
            send_item(random_request(step));
            sent++;
         end
         pause_sender($urandom_range(0, 12));
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: its own stall pattern, plus one long hold-off on request.
   // ---------------------------------------------------------------------
   initial begin : receiver
      int style;
      int run;
      rsp_stall = 1'b0;
      forever begin
         if (want_long_hold && !long_hold_done) begin
            // hold everything back; the block fills and stalls its request side
            long_hold_started = 1'b1;
            repeat (LONG_HOLD) @(negedge clock) rsp_stall <= 1'b1;
            long_hold_done = 1'b1;
         end
         style = $urandom_range(0, 3);
         run   = $urandom_range(8, 60);
         for (int k = 0; k < run; k++) begin
            @(negedge clock);
            case (style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= (k % 3 == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves an item for too long.
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t watchdog: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_repeat_event_scheduler: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      req_type tick_item;
      req_type clear_item;
      req_type sweep_item;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      reset      = 1'b1;
      items_sent = 0;
      tick_item  = make_request(OP_TICK, '0, '0, '0, '0, '0);
      clear_item = make_request(OP_CLEAR, '0, '0, '0, '0, '0);

      // step settings per phase: one second, frozen timers, largest, smallest, random
      phase_step[0] = 16'h0100;
      phase_step[1] = 16'h0000;
      phase_step[2] = 16'hFFFF;
      phase_step[3] = 16'h0001;
      phase_step[4] = TIME_BITS'($urandom);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset frame_step of 4.
      // Immediate plays with every field at its top and at zero.
      send_item(make_request(OP_SCHEDULE, 11'h7FF, 16'h0000, 7'd1, 16'hFFFF, 16'hFFFF));
      send_item(make_request(OP_SCHEDULE, 11'h000, 16'h0000, 7'd1, 16'h0000, 16'h0000));
      // zero plays is stored as one play
      send_item(make_request(OP_SCHEDULE, 11'h005, 16'h0000, 7'd0, 16'h0000, 16'h1234));
      // most plays with no gap: play, move to play, play, ...
      send_item(make_request(OP_SCHEDULE, 11'h7FF, 16'h0000, 7'h7F, 16'h0000, 16'hFFFF));
      // one play behind a delay is stored, not immediate
      send_item(make_request(OP_SCHEDULE, 11'h009, 16'd4, 7'd1, 16'h0000, 16'h0007));
      // longest delay and gap
      send_item(make_request(OP_SCHEDULE, 11'h00A, 16'hFFFF, 7'd3, 16'hFFFF, 16'hA5A5));
      // timer below the step saturates at zero
      send_item(make_request(OP_SCHEDULE, 11'h00B, 16'd3, 7'd2, 16'd8, 16'h5A5A));
      // spare code with every bit set: ignored
      send_item(make_request(OP_UNUSED, 11'h7FF, 16'hFFFF, 7'h7F, 16'hFFFF, 16'hFFFF));
      repeat (6) send_item(tick_item);
      // clear drops every slot and the write pointer; the next tick is silent
      send_item(clear_item);
      send_item(tick_item);
      send_item(make_request(OP_SCHEDULE, 11'h2AA, 16'h0000, 7'd2, 16'h0000, 16'h5555));
      repeat (3) send_item(tick_item);
      // a tick ignores its other fields
      send_item(make_request(OP_TICK, 11'h7FF, 16'hFFFF, 7'h7F, 16'hFFFF, 16'hFFFF));
      drain_plays();

      for (int p = 0; p < PHASES; p++) begin
         write_frame_step(phase_step[p]);
         if (p == 1) begin
            // pause mid phase until every play event is back
            send_random(RANDOM_PER_PHASE / 2, phase_step[p]);
            drain_plays();
            send_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2, phase_step[p]);
         end else if (p == 2) begin
            // fill every slot with a ready play so one tick emits a full sweep,
            // and hold the receiver off across it while requests keep coming
            want_long_hold = 1'b1;
            send_item(clear_item);
            for (int s = 0; s < SLOT_COUNT; s++) begin
               sweep_item = random_request(phase_step[p]);
               sweep_item.operation   = OP_SCHEDULE;
               sweep_item.start_delay = '0;
               if (sweep_item.play_total == COUNT_W'(1)) sweep_item.play_total = '0;
               send_item(sweep_item);
            end
            wait (long_hold_started);
            send_item(tick_item);
            send_random(RANDOM_PER_PHASE, phase_step[p]);
         end else begin
            send_random(RANDOM_PER_PHASE, phase_step[p]);
         end
         drain_plays();
      end

      $display("tb_repeat_event_scheduler: %0d requests over %0d frame_step settings, %0d ticks",
               items_sent, PHASES + 1, tick_count);
      $display("tb_repeat_event_scheduler: %0d play events checked, %0d immediate, widest tick %0d",
               event_count, immediate_count, widest_tick);
      if (fail_count == 0 && pending_plays == 0) begin
         $display("tb_repeat_event_scheduler: done, clean");
      end else begin
         $display("tb_repeat_event_scheduler: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/rsched_pkg.sv
rtl/rsched_ram.sv
rtl/rsched_emit.sv
rtl/repeat_event_scheduler.sv
test/play_event_checker.sv
test/tb_repeat_event_scheduler.sv
